// ===== rtl/bbpp_pkg.sv =====
`timescale 1ns / 1ps

package bbpp_pkg;

	// Default coordinate width (signed Q16.16 at 32 bits).
	localparam int COORD_WIDTH_DEF = 32;

	// Parameter format: unsigned Q1.15, ONE_Q15 is 1.0.
	localparam int PARAM_W = 16;
	localparam logic [PARAM_W-1:0] ONE_Q15 = 16'h8000;

	// Weights at scale 2^30 never exceed 2^30 by much and fit in 31 bits.
	localparam int WEIGHT_W = 31;
	// Exact 1-D Bernstein terms at scale 2^45.
	localparam int EXACT_W = 48;

	localparam int GRID_N = 16;
	localparam int AXES = 3;

	// Input command codes, carried on tuser.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

endpackage

// ===== rtl/bicubic_bezier_patch_point_core.sv =====
`timescale 1ns / 1ps
// Bicubic Bezier patch point core.
// An evaluate beat passes through all pipeline stages and leaves from the stage 8 register.
// Throughput: one beat per cycle; the eight pipeline stages advance together and hold
// as a whole only while the output beat waits on m_axis_tready.
// Reset: arst_n clears all pipeline valid bits; the control point grid is not reset
// and must be loaded before the first evaluate.
module bicubic_bezier_patch_point_core #(
	parameter int COORD_WIDTH = bbpp_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0 up: point_index(4), coord_x, coord_y, coord_z (COORD_WIDTH each),
	// u_param(16), v_param(16), zero fill to whole bytes.
	input  logic [((4 + 3 * COORD_WIDTH + 32 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// Field: command (0 = load control point, 1 = evaluate surface point).
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Fields from bit 0 up: point_x, point_y, point_z (COORD_WIDTH each), zero fill.
	output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);
	import bbpp_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
	// Coordinate times tensor weight, and the sum of sixteen of them.
	localparam int PW = CW + WEIGHT_W + 1;
	localparam int SW = PW + 4;
	localparam int RW = SW - 30;
	localparam int U_LO = 4 + 3 * CW;

	// Every stage moves when the output slot is free or being emptied.
	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4;

	// Load payload rides along until the stage where the grid is read, so that
	// loads and evaluates touch the grid in arrival order.
	logic [3:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [CW-1:0] crd_s1 [AXES];
	logic signed [CW-1:0] crd_s2 [AXES];
	logic signed [CW-1:0] crd_s3 [AXES];
	logic signed [CW-1:0] crd_s4 [AXES];

	logic signed [CW-1:0] grid_q [AXES][GRID_N];

	// Index 0 is u, index 1 is v.
	logic [PARAM_W-1:0] t_s1 [2];
	logic [PARAM_W-1:0] s_s1 [2];
	logic [PARAM_W-1:0] t_s2 [2];
	logic [PARAM_W-1:0] s_s2 [2];
	logic [31:0] ss_s2 [2];
	logic [31:0] tt_s2 [2];
	logic [WEIGHT_W-1:0] w_s3 [2][4];
	logic [WEIGHT_W-1:0] tw_s4 [GRID_N];
	logic signed [PW-1:0] p_s5 [AXES][GRID_N];
	logic signed [SW-1:0] part_s6 [AXES][4];
	logic signed [SW-1:0] tot_s7 [AXES];
	logic signed [CW-1:0] pt_s8 [AXES];

	// Valid and command pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			// Loads end at the grid write; only evaluates go on.
			vld_s5 <= vld_s4 && (cmd_s4 == CMD_EVAL);
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Stage 1: unpack and clamp the parameters to one.
	logic [PARAM_W-1:0] par_in [2];
	always_comb begin
		par_in[0] = s_axis_tdata[U_LO +: PARAM_W];
		par_in[1] = s_axis_tdata[U_LO + PARAM_W +: PARAM_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_t'(s_axis_tuser);
			idx_s1 <= s_axis_tdata[3:0];
			for (int a = 0; a < AXES; a++) begin
				crd_s1[a] <= s_axis_tdata[4 + a * CW +: CW];
			end
			for (int d = 0; d < 2; d++) begin
				if (par_in[d] > ONE_Q15) begin
					t_s1[d] <= ONE_Q15;
					s_s1[d] <= '0;
				end else begin
					t_s1[d] <= par_in[d];
					s_s1[d] <= ONE_Q15 - par_in[d];
				end
			end
		end
	end

	// Stage 2: squares of s and t.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			idx_s2 <= idx_s1;
			crd_s2 <= crd_s1;
			for (int d = 0; d < 2; d++) begin
				t_s2[d] <= t_s1[d];
				s_s2[d] <= s_s1[d];
				ss_s2[d] <= 32'(s_s1[d]) * 32'(s_s1[d]);
				tt_s2[d] <= 32'(t_s1[d]) * 32'(t_s1[d]);
			end
		end
	end

	// Stage 3: the four exact cubic terms, rounded half up from 2^45 to 2^30.
	logic [EXACT_W-1:0] ex [2][4];
	always_comb begin
		for (int d = 0; d < 2; d++) begin
			ex[d][0] = EXACT_W'(ss_s2[d]) * EXACT_W'(s_s2[d]);
			ex[d][1] = 3 * (EXACT_W'(ss_s2[d]) * EXACT_W'(t_s2[d]));
			ex[d][2] = 3 * (EXACT_W'(tt_s2[d]) * EXACT_W'(s_s2[d]));
			ex[d][3] = EXACT_W'(tt_s2[d]) * EXACT_W'(t_s2[d]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			idx_s3 <= idx_s2;
			crd_s3 <= crd_s2;
			for (int d = 0; d < 2; d++) begin
				for (int k = 0; k < 4; k++) begin
					w_s3[d][k] <= WEIGHT_W'((ex[d][k] + EXACT_W'(1 << 14)) >> 15);
				end
			end
		end
	end

	// Stage 4: sixteen tensor weights Bu(i) * Bv(j), rounded half up to 2^30.
	logic [2*WEIGHT_W-1:0] twx [GRID_N];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				twx[i*4+j] = (2*WEIGHT_W)'(w_s3[0][i]) * (2*WEIGHT_W)'(w_s3[1][j])
					+ (2*WEIGHT_W)'(1 << 29);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s4 <= cmd_s3;
			idx_s4 <= idx_s3;
			crd_s4 <= crd_s3;
			for (int k = 0; k < GRID_N; k++) begin
				tw_s4[k] <= WEIGHT_W'(twx[k] >> 30);
			end
		end
	end

	// The grid is written and read at the same stage, which keeps order.
	always_ff @(posedge clk) begin
		if (en && vld_s4 && (cmd_s4 == CMD_LOAD)) begin
			for (int a = 0; a < AXES; a++) begin
				grid_q[a][idx_s4] <= crd_s4[a];
			end
		end
	end

	// Stage 5: forty-eight signed products, one per grid point and axis.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				for (int k = 0; k < GRID_N; k++) begin
					p_s5[a][k] <= PW'(grid_q[a][k]) * $signed({1'b0, tw_s4[k]});
				end
			end
		end
	end

	// Stage 6: first adder tree level, four groups of four per axis.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				for (int g = 0; g < 4; g++) begin
					part_s6[a][g] <= SW'(p_s5[a][4*g]) + SW'(p_s5[a][4*g+1])
						+ SW'(p_s5[a][4*g+2]) + SW'(p_s5[a][4*g+3]);
				end
			end
		end
	end

	// Stage 7: final sum plus the half unit for rounding.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				tot_s7[a] <= part_s6[a][0] + part_s6[a][1] + part_s6[a][2]
					+ part_s6[a][3] + SW'(1 << 29);
			end
		end
	end

	// Stage 8: drop the weight scale and saturate to the coordinate range.
	logic signed [RW-1:0] rnd [AXES];
	logic fits [AXES];
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			rnd[a] = RW'(tot_s7[a] >>> 30);
			fits[a] = (rnd[a][RW-1:CW-1] == '0) || (rnd[a][RW-1:CW-1] == '1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				if (fits[a]) begin
					pt_s8[a] <= rnd[a][CW-1:0];
				end else if (rnd[a][RW-1]) begin
					pt_s8[a] <= {1'b1, {(CW-1){1'b0}}};
				end else begin
					pt_s8[a] <= {1'b0, {(CW-1){1'b1}}};
				end
			end
		end
	end

	assign m_axis_tvalid = vld_s8;
	assign m_axis_tdata = OUT_W'({pt_s8[2], pt_s8[1], pt_s8[0]});

	// A finished evaluate in the last adder stage must reach the output register.
	a_eval_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s7) |=> m_axis_tvalid)
		else $error("evaluate beat lost before the output register");

	// While stalled the command in the grid stage must not change.
	a_stall_holds_grid_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s4) && $stable(cmd_s4) && $stable(idx_s4)))
		else $error("grid stage moved during a stall");

	// At u = 0 the first u weight is exactly one.
	a_weight_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(en && t_s2[0] == '0) |=> (w_s3[0][0] == WEIGHT_W'(1 << 30)))
		else $error("Bernstein weight at u = 0 is not one");

endmodule

// ===== sim/tb_bicubic_bezier_patch_point_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bicubic Bezier patch point core.
// An initial block loads a queue with control point loads and surface evaluations.
// A clocked driver sends them in bursts of random length with random gaps.
// Each accepted evaluate beat is predicted from the bench's own copy of the grid.
// A monitor checks the output beats in order against those predictions.
module tb_bicubic_bezier_patch_point_core;
	import bbpp_pkg::*;

	localparam int CW = 32;
	localparam int IN_W = ((4 + 3 * CW + 32 + 7) / 8) * 8;
	localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1700;

	typedef struct packed {
		cmd_t cmd;
		logic [3:0] idx;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic [PARAM_W-1:0] u;
		logic [PARAM_W-1:0] v;
	} patch_op_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} surf_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	bicubic_bezier_patch_point_core #(.COORD_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Operations still to be sent, and surface points still to come out.
	patch_op_t pending_ops[$];
	surf_point_t expected_points[$];

	// The bench's own copy of the control point grid.
	logic signed [CW-1:0] grid_x[GRID_N];
	logic signed [CW-1:0] grid_y[GRID_N];
	logic signed [CW-1:0] grid_z[GRID_N];

	int errors = 0;
	int loads_sent = 0;
	int evals_sent = 0;
	int points_checked = 0;
	int saturated_seen = 0;
	bit stim_done = 1'b0;

	// The four cubic Bernstein weights of one parameter, each rounded to scale 2^30.
	// Parameters above one are clamped to one first.
	function automatic logic [3:0][31:0] bernstein_weights(input logic [PARAM_W-1:0] t_in);
		longint unsigned t, s;
		longint unsigned exact[4];
		logic [3:0][31:0] w;
		t = (t_in > ONE_Q15) ? 64'(ONE_Q15) : 64'(t_in);
		s = 64'(ONE_Q15) - t;
		exact[0] = s * s * s;
		exact[1] = 3 * s * s * t;
		exact[2] = 3 * s * t * t;
		exact[3] = t * t * t;
		for (int k = 0; k < 4; k++)
			w[k] = 32'((exact[k] + 64'd16384) >> 15);
		return w;
	endfunction

	// Rounds an exact weighted sum at scale 2^30 to the coordinate format and clamps it.
	// Rounded weights can add up to a little more than one, so the clamp does matter.
	function automatic logic [CW-1:0] round_to_coord(input logic signed [95:0] acc);
		logic signed [95:0] r;
		r = (acc + (96'sd1 <<< 29)) >>> 30;
		if (r > 96'sd2147483647)
			return 32'h7FFF_FFFF;
		if (r < -96'sd2147483648)
			return 32'h8000_0000;
		return r[CW-1:0];
	endfunction

	function automatic surf_point_t surface_point(input logic [PARAM_W-1:0] u,
			input logic [PARAM_W-1:0] v);
		logic [3:0][31:0] wu, wv;
		longint unsigned w;
		logic signed [95:0] ax, ay, az, wt, cx, cy, cz;
		surf_point_t p;
		wu = bernstein_weights(u);
		wv = bernstein_weights(v);
		ax = '0;
		ay = '0;
		az = '0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				w = (64'(wu[i]) * 64'(wv[j]) + 64'd536870912) >> 30;
				wt = 96'(w);
				cx = grid_x[i * 4 + j];
				cy = grid_y[i * 4 + j];
				cz = grid_z[i * 4 + j];
				ax += cx * wt;
				ay += cy * wt;
				az += cz * wt;
			end
		end
		p.x = round_to_coord(ax);
		p.y = round_to_coord(ay);
		p.z = round_to_coord(az);
		return p;
	endfunction

	// Applies one accepted beat to the grid copy, or queues the point it must produce.
	task automatic apply_op(input patch_op_t op);
		surf_point_t p;
		if (op.cmd == CMD_LOAD) begin
			grid_x[op.idx] = op.x;
			grid_y[op.idx] = op.y;
			grid_z[op.idx] = op.z;
			loads_sent++;
		end else begin
			p = surface_point(op.u, op.v);
			if (p.x == 32'h7FFF_FFFF || p.x == 32'h8000_0000)
				saturated_seen++;
			expected_points = {expected_points, p};
			evals_sent++;
		end
	endtask

	function automatic patch_op_t load_op(input logic [3:0] idx, input logic [CW-1:0] x,
			input logic [CW-1:0] y, input logic [CW-1:0] z);
		patch_op_t op;
		op.cmd = CMD_LOAD;
		op.idx = idx;
		op.x = x;
		op.y = y;
		op.z = z;
		// A load ignores the parameters; random bits there must not matter.
		op.u = PARAM_W'($urandom);
		op.v = PARAM_W'($urandom);
		return op;
	endfunction

	function automatic patch_op_t eval_op(input logic [PARAM_W-1:0] u,
			input logic [PARAM_W-1:0] v);
		patch_op_t op;
		op.cmd = CMD_EVAL;
		// An evaluate ignores the index and the coordinates.
		op.idx = 4'($urandom);
		op.x = $urandom;
		op.y = $urandom;
		op.z = $urandom;
		op.u = u;
		op.v = v;
		return op;
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 131072)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [PARAM_W-1:0] rand_param();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return ONE_Q15;
			// Above one: the core must clamp these to one.
			2: return PARAM_W'($urandom_range(32769, 65535));
			default: return PARAM_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// Stimulus: a directed opening, then random traffic.
	initial begin
		// Every slot is written before the first evaluate, since the grid has no reset value.
		// Extremes first: all x at the positive limit, all y at the negative limit.
		for (int k = 0; k < GRID_N; k++)
			pending_ops = {pending_ops, load_op(4'(k), 32'h7FFF_FFFF, 32'h8000_0000,
				(k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000)};
		// Corners, edges, clamping of parameters above one, and the middle where the
		// weight rounding overshoots and the result has to saturate.
		pending_ops = {pending_ops, eval_op(16'd0, 16'd0)};
		pending_ops = {pending_ops, eval_op(ONE_Q15, ONE_Q15)};
		pending_ops = {pending_ops, eval_op(16'hFFFF, 16'hFFFF)};
		pending_ops = {pending_ops, eval_op(16'd16384, 16'd16384)};
		pending_ops = {pending_ops, eval_op(16'd10923, 16'd21845)};
		pending_ops = {pending_ops, eval_op(16'h7FFF, 16'h0001)};
		pending_ops = {pending_ops, eval_op(16'h8001, 16'd0)};
		// Reload one slot with a small value and read it back at its corner.
		pending_ops = {pending_ops,
			load_op(4'd15, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_0000)};
		pending_ops = {pending_ops, eval_op(ONE_Q15, ONE_Q15)};

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 30)
				pending_ops = {pending_ops, load_op(4'($urandom), rand_coord(),
					rand_coord(), rand_coord())};
			else
				pending_ops = {pending_ops, eval_op(rand_param(), rand_param())};
		end
		stim_done = 1'b1;
	end

	// Reset held low from time zero, released on a falling edge.
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Input side: a beat counts at a rising edge with tvalid and tready both high.
	bit in_taken = 1'b0;
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			apply_op(pending_ops.pop_front());
	end

	// Driver: bursts of random length, random gaps between them.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !in_taken)) begin
			if (gap_left > 0 || pending_ops.size() == 0) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= pending_ops[0].cmd;
				s_axis_tdata <= {4'b0, pending_ops[0].v, pending_ops[0].u, pending_ops[0].z,
					pending_ops[0].y, pending_ops[0].x, pending_ops[0].idx};
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// Some bursts run back to back with no gap at all.
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: a stall pattern of its own, plus one long hold-off once traffic runs,
	// so that the pipeline fills and the core has to drop s_axis_tready.
	int stall_phase = 0;
	int hold_off = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (!hold_done && evals_sent > 300) begin
			hold_done <= 1'b1;
			hold_off <= 200;
			m_axis_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else begin
			stall_phase <= (stall_phase + 1) % 97;
			if (stall_phase < 30)
				m_axis_tready <= 1'b1;
			else if (stall_phase < 60)
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			else
				m_axis_tready <= ($urandom_range(0, 1) != 0);
		end
	end

	// Monitor: each output beat against the oldest predicted point.
	always @(posedge clk) begin
		surf_point_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x = m_axis_tdata[CW-1:0];
			got.y = m_axis_tdata[2*CW-1:CW];
			got.z = m_axis_tdata[3*CW-1:2*CW];
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t: output beat with no point expected: x=%h y=%h z=%h",
					$time, got.x, got.y, got.z);
			end else begin
				want = expected_points.pop_front();
				points_checked++;
				if (got.x !== want.x) begin
					errors++;
					$display("%0t: point_x expected %h actual %h", $time, want.x, got.x);
				end
				if (got.y !== want.y) begin
					errors++;
					$display("%0t: point_y expected %h actual %h", $time, want.y, got.y);
				end
				if (got.z !== want.z) begin
					errors++;
					$display("%0t: point_z expected %h actual %h", $time, want.z, got.z);
				end
			end
		end
	end

	// End of run: all beats sent, all points out, then a margin past the pipeline latency.
	initial begin
		wait (stim_done && arst_n);
		wait (pending_ops.size() == 0 && expected_points.size() == 0);
		repeat (30) @(posedge clk);
		$display("Sent %0d grid loads and %0d evaluations; checked %0d surface points.",
			loads_sent, evals_sent, points_checked);
		$display("Expected points at a saturation limit in x: %0d.", saturated_seen);
		if (errors == 0 && expected_points.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d beats unsent and %0d points outstanding.",
			pending_ops.size(), expected_points.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
